// ===== rtl/bddisp_pkg.sv =====
// ----------------------------------------------------------------------------
// bddisp_pkg
// Shared types and constants for the decimal digit display unit.
// ----------------------------------------------------------------------------
package bddisp_pkg;

    localparam int VALUE_W        = 32;
    localparam int BIT_CNT_W      = $clog2(VALUE_W);
    localparam int DIGIT_W        = 4;
    localparam int MAX_DIGITS_DEF = 10;

    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
    localparam logic [5:0]         ASCII_ZERO   = 6'd48;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [7:0]         start_column;
        logic [7:0]         digit_count;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] column;
        logic [5:0] char_code;
        logic       last;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/binary_to_decimal_digit_display_unit.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_digit_display_unit
// Converts a 32-bit unsigned value to decimal with a bit-serial double dabble
// and emits the low digits as ASCII characters with their display columns.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_in_data  (t_in_beat)
//  out      output     o_out_valid / i_out_ready  o_out_data (t_out_beat)
//
//  One item at a time: an accept step, then the shifts (one value bit per
//  cycle through the bcd shift register), then alignment steps that drop
//  the unshown high digits (the last one only moves on to emit), then one
//  digit beat per shown digit, most significant first.
//  A count of zero returns to idle right after the accept.
//  Output stalls hold the emit loop; the output register decouples the sides.
//  Synchronous active-low reset clears the control state only.
// ----------------------------------------------------------------------------
module binary_to_decimal_digit_display_unit #(
    parameter int MAX_DIGITS = bddisp_pkg::MAX_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  bddisp_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output bddisp_pkg::t_out_beat o_out_data
);

    localparam int BCD_W = MAX_DIGITS * bddisp_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    bddisp_pkg::t_state r_state, n_state;

    logic [bddisp_pkg::VALUE_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]                 r_bcd, n_bcd;
    logic [bddisp_pkg::BIT_CNT_W-1:0] r_bit, n_bit;
    logic [CNT_W-1:0]                 r_cnt, n_cnt;
    logic [CNT_W-1:0]                 r_skip, n_skip;
    logic [7:0]                       r_col, n_col;
    logic                             r_out_valid, n_out_valid;
    bddisp_pkg::t_out_beat            r_out, n_out;

    logic [BCD_W-1:0]                 bcd_adj;
    logic [CNT_W-1:0]                 cnt_clamped;
    logic [bddisp_pkg::DIGIT_W-1:0]   top_digit;
    logic                             out_free;

    // add-3 correction, each digit on its own
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*bddisp_pkg::DIGIT_W +: bddisp_pkg::DIGIT_W]
                    >= bddisp_pkg::DABBLE_LIMIT) begin
                bcd_adj[d*bddisp_pkg::DIGIT_W +: bddisp_pkg::DIGIT_W] =
                    r_bcd[d*bddisp_pkg::DIGIT_W +: bddisp_pkg::DIGIT_W]
                    + bddisp_pkg::DABBLE_ADD;
            end else begin
                bcd_adj[d*bddisp_pkg::DIGIT_W +: bddisp_pkg::DIGIT_W] =
                    r_bcd[d*bddisp_pkg::DIGIT_W +: bddisp_pkg::DIGIT_W];
            end
        end
    end

    assign cnt_clamped = (i_in_data.digit_count > 8'(MAX_DIGITS))
                       ? CNT_W'(MAX_DIGITS) : CNT_W'(i_in_data.digit_count);
    assign top_digit   = r_bcd[BCD_W-1 -: bddisp_pkg::DIGIT_W];
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_skip      = r_skip;
        n_col       = r_col;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;

        case (r_state)
            bddisp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_bin  = i_in_data.value;
                    n_bcd  = '0;
                    n_bit  = '0;
                    n_col  = i_in_data.start_column;
                    n_cnt  = cnt_clamped;
                    n_skip = CNT_W'(MAX_DIGITS) - cnt_clamped;
                    if (cnt_clamped != '0) begin
                        n_state = bddisp_pkg::ST_CONV;
                    end
                end
            end
            bddisp_pkg::ST_CONV: begin
                {n_bcd, n_bin} = {bcd_adj, r_bin} << 1;
                n_bit = r_bit + 1'b1;
                if (r_bit == bddisp_pkg::BIT_CNT_W'(bddisp_pkg::VALUE_W - 1)) begin
                    n_state = bddisp_pkg::ST_ALIGN;
                end
            end
            bddisp_pkg::ST_ALIGN: begin
                // drop the unshown high digits so the first one sits on top
                if (r_skip == '0) begin
                    n_state = bddisp_pkg::ST_EMIT;
                end else begin
                    n_bcd  = r_bcd << bddisp_pkg::DIGIT_W;
                    n_skip = r_skip - 1'b1;
                end
            end
            bddisp_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.column    = r_col;
                    n_out.char_code = bddisp_pkg::ASCII_ZERO + 6'(top_digit);
                    n_out.last      = (r_cnt == CNT_W'(1));
                    n_bcd           = r_bcd << bddisp_pkg::DIGIT_W;
                    n_col           = r_col + 8'd1;
                    n_cnt           = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = bddisp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = bddisp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bddisp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_skip <= n_skip;
        r_col  <= n_col;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== test/bddisp_digit_checker.sv =====
// ----------------------------------------------------------------------------
// bddisp_digit_checker
// Watches both channels of the decimal digit display unit. Every accepted
// input beat is turned into the digit beats it should produce, and every
// accepted output beat is compared field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module bddisp_digit_checker
    import bddisp_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_digits_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    t_out_beat digit_beats_q[$];

    initial begin
        o_fail_count  = 0;
        o_digits_owed = 0;
    end

    // low digits of the value, most significant shown digit first
    task automatic queue_digit_beats(input t_in_beat b);
        logic [3:0]      digits [MAX_DIGITS];
        longint unsigned rest;
        int              shown;
        t_out_beat       beat;
        rest = b.value;
        for (int k = 0; k < MAX_DIGITS; k++) begin
            digits[k] = 4'(rest % 10);
            rest      = rest / 10;
        end
        shown = (b.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(b.digit_count);
        for (int k = 0; k < shown; k++) begin
            beat.column    = b.start_column + 8'(k);
            beat.char_code = ASCII_ZERO + 6'(digits[shown - 1 - k]);
            beat.last      = (k == shown - 1);
            digit_beats_q.push_back(beat);
        end
    endtask

    task automatic compare_digit_beat(input t_out_beat got);
        t_out_beat want;
        if (digit_beats_q.size() == 0) begin
            $error("unexpected digit beat: column=%0d char_code=%0d last=%0b",
                   got.column, got.char_code, got.last);
            o_fail_count++;
        end else begin
            want = digit_beats_q.pop_front();
            if (got.column !== want.column) begin
                $error("column: expected %0d, actual %0d", want.column, got.column);
                o_fail_count++;
            end
            if (got.char_code !== want.char_code) begin
                $error("char_code: expected %0d, actual %0d",
                       want.char_code, got.char_code);
                o_fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, got.last);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                queue_digit_beats(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                compare_digit_beat(i_out_data);
            end
        end
        o_digits_owed = digit_beats_q.size();
    end

endmodule

// ===== test/tb_binary_to_decimal_digit_display_unit.sv =====
// ----------------------------------------------------------------------------
// tb_binary_to_decimal_digit_display_unit
// Drives directed and random values, columns and digit counts into the
// display unit with random idling on both sides, and gives the verdict from
// the failure count of the checker, failing also at the cycle limit.
// ----------------------------------------------------------------------------
module tb_binary_to_decimal_digit_display_unit
    import bddisp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 260;
    localparam int IDLE_PCT     = 34;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    int fail_count;
    int digits_owed;
    int cycle_count;
    bit no_idle;

    binary_to_decimal_digit_display_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    bddisp_digit_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_digits_owed(digits_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // output side stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // valid stays up from one beat to the next unless a gap is drawn
    task automatic send_value(input logic [31:0] value, input logic [7:0] col,
                              input logic [7:0] count);
        t_in_beat b;
        b.value        = value;
        b.start_column = col;
        b.digit_count  = count;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 9);
            1:       v = $urandom_range(0, 99999);
            2: begin
                // around a power of ten
                v = 32'd1;
                repeat ($urandom_range(1, 9)) v = v * 10;
                v = v + 32'($urandom_range(0, 2)) - 32'd1;
            end
            3:       v = 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return 8'd0;
        else if (pick < 20)
            return 8'($urandom_range(11, 255));
        else
            return 8'($urandom_range(1, 10));
    endfunction

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        no_idle    = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, clamping, padding, truncation, wrap
        send_value(32'd0,          8'd0,   8'd1);
        send_value(32'hFFFF_FFFF,  8'd0,   8'd10);
        send_value(32'hFFFF_FFFF,  8'hFF,  8'hFF);
        send_value(32'd123,        8'd5,   8'd0);
        send_value(32'd0,          8'd0,   8'd0);
        send_value(32'd98765,      8'd3,   8'd11);
        send_value(32'd7,          8'd20,  8'd10);
        send_value(32'd123456789,  8'd40,  8'd3);
        send_value(32'd1000000000, 8'd250, 8'd10);
        send_value(32'd45,         8'd255, 8'd2);
        send_value(32'd999999999,  8'd1,   8'd9);
        send_value(32'h8000_0000,  8'hAA,  8'h80);
        send_value(32'h5555_5555,  8'h55,  8'd10);
        send_value(32'hAAAA_AAAA,  8'd128, 8'd6);
        send_value(32'd42,         8'd17,  8'd5);
        send_value(32'd1,          8'd254, 8'd4);
        send_value(32'd4294967,    8'd9,   8'd7);
        send_value(32'd10,         8'd0,   8'd1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 100 && n < 160);
            send_value(random_value(), 8'($urandom_range(0, 255)), random_count());
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (digits_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
